>>> design/touch_event_assembler_affine_top_defines.svh
// Assertion macros for the touch event assembler.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef TOUCH_EVENT_ASSEMBLER_AFFINE_TOP_DEFINES_SVH
`define TOUCH_EVENT_ASSEMBLER_AFFINE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define TEA_ASSERT_SAME(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("tea check failed");
`define TEA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("tea check failed");
`else
`define TEA_ASSERT_SAME(lbl, ck, rn, ante, cons)
`define TEA_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

>>> design/tea_pkg.sv
// Shared types, event codes and helpers for the touch event assembler.
// No dependencies.
package tea_pkg;
	localparam int PANEL_SIZE = 4096;

	localparam logic [15:0] EV_SYN       = 16'h0000;
	localparam logic [15:0] EV_KEY       = 16'h0001;
	localparam logic [15:0] EV_ABS       = 16'h0003;
	localparam logic [15:0] KEY_CONTACT  = 16'h014a;
	localparam logic [15:0] ABS_X        = 16'h0000;
	localparam logic [15:0] ABS_Y        = 16'h0001;
	localparam logic [15:0] ABS_PRESS    = 16'h0018;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_CORRECT_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_X_FROM_X       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_X_FROM_Y       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_FROM_X       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_FROM_Y       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET       = 3'd6;

	typedef enum logic [1:0] {
		ST_NONE = 2'd0,
		ST_DOWN = 2'd1,
		ST_UP   = 2'd2
	} contact_state_t;

	typedef struct packed {
		logic               correct_enable;
		logic signed [31:0] x_from_x;
		logic signed [31:0] x_from_y;
		logic signed [31:0] x_offset;
		logic signed [31:0] y_from_x;
		logic signed [31:0] y_from_y;
		logic signed [31:0] y_offset;
	} cfg_t;

	typedef struct packed {
		logic [15:0]        event_type;
		logic [15:0]        event_code;
		logic signed [31:0] event_value;
	} event_t;

	typedef struct packed {
		contact_state_t     contact_state;
		logic signed [15:0] coord_x;
		logic signed [15:0] coord_y;
		logic signed [31:0] pressure;
	} result_t;

	function automatic logic signed [15:0] sat16_of32(input logic signed [31:0] v);
		logic signed [15:0] r;
		if (v > 32'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -32'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction
endpackage

>>> design/tea_cfg_regs.sv
// Configuration register file for the touch event assembler.
// Depends on tea_pkg.
module tea_cfg_regs
	import tea_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [31:0]          wr_data,
	output cfg_t                 cfg
);
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.correct_enable <= 1'b0;
			cfg_q.x_from_x       <= 32'sd65536;
			cfg_q.x_from_y       <= '0;
			cfg_q.x_offset       <= '0;
			cfg_q.y_from_x       <= '0;
			cfg_q.y_from_y       <= 32'sd65536;
			cfg_q.y_offset       <= '0;
		end else if (wr_en) begin
			case (wr_index)
				CFG_CORRECT_ENABLE: cfg_q.correct_enable <= wr_data[0];
				CFG_X_FROM_X:       cfg_q.x_from_x       <= wr_data;
				CFG_X_FROM_Y:       cfg_q.x_from_y       <= wr_data;
				CFG_X_OFFSET:       cfg_q.x_offset       <= wr_data;
				CFG_Y_FROM_X:       cfg_q.y_from_x       <= wr_data;
				CFG_Y_FROM_Y:       cfg_q.y_from_y       <= wr_data;
				CFG_Y_OFFSET:       cfg_q.y_offset       <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

>>> design/tea_affine.sv
// One Q16.16 affine output: cx*x + cy*y + off, truncated to integer, saturated to 16 bits.
// Depends on tea_pkg.
module tea_affine
	import tea_pkg::*;
(
	input  logic signed [31:0] cx,
	input  logic signed [31:0] cy,
	input  logic signed [31:0] off,
	input  logic signed [31:0] x,
	input  logic signed [31:0] y,
	output logic signed [15:0] q
);
	logic signed [63:0] prod_a;
	logic signed [63:0] prod_b;
	logic signed [65:0] acc;
	logic signed [65:0] acc_adj;
	logic signed [49:0] quo;

	assign prod_a  = cx * x;
	assign prod_b  = cy * y;
	assign acc     = 66'(prod_a) + 66'(prod_b) + 66'(off);
	assign acc_adj = acc[65] ? (acc + 66'sd65535) : acc;
	assign quo     = $signed(acc_adj[65:16]);

	always_comb begin
		if (quo > 50'sd32767) begin
			q = 16'sh7fff;
		end else if (quo < -50'sd32768) begin
			q = 16'sh8000;
		end else begin
			q = quo[15:0];
		end
	end
endmodule

>>> design/tea_frame.sv
// Frame state, last reported coordinates and result formation for one event.
// Depends on tea_pkg and tea_affine.
module tea_frame
	import tea_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    evt_en,
	input  event_t  evt,
	input  cfg_t    cfg,
	output result_t res
);
	contact_state_t     frame_state_q;
	logic signed [31:0] frame_x_q;
	logic signed [31:0] frame_y_q;
	logic signed [31:0] held_pressure_q;
	logic signed [15:0] last_x_q;
	logic signed [15:0] last_y_q;

	logic               is_key;
	logic               is_abs;
	logic               is_syn;
	logic signed [33:0] mirror;
	logic signed [31:0] mirror_sat;
	logic signed [31:0] x_sel;
	logic signed [31:0] y_sel;
	logic signed [15:0] corr_x;
	logic signed [15:0] corr_y;
	logic signed [15:0] new_x;
	logic signed [15:0] new_y;
	logic               frame_up;

	assign is_key = (evt.event_type == EV_KEY);
	assign is_abs = (evt.event_type == EV_ABS);
	assign is_syn = (evt.event_type == EV_SYN);

	assign mirror = 34'(PANEL_SIZE) - 34'(evt.event_value);
	always_comb begin
		if (mirror > 34'sd2147483647) begin
			mirror_sat = 32'sh7fffffff;
		end else if (mirror < -34'sd2147483648) begin
			mirror_sat = 32'sh80000000;
		end else begin
			mirror_sat = mirror[31:0];
		end
	end

	assign x_sel = (frame_x_q != '0) ? frame_x_q : 32'(last_x_q);
	assign y_sel = (frame_y_q != '0) ? frame_y_q : 32'(last_y_q);

	tea_affine u_aff_x (
		.cx  (cfg.x_from_x),
		.cy  (cfg.x_from_y),
		.off (cfg.x_offset),
		.x   (x_sel),
		.y   (y_sel),
		.q   (corr_x)
	);

	tea_affine u_aff_y (
		.cx  (cfg.y_from_x),
		.cy  (cfg.y_from_y),
		.off (cfg.y_offset),
		.x   (x_sel),
		.y   (y_sel),
		.q   (corr_y)
	);

	assign frame_up = (frame_state_q == ST_UP);
	assign new_x    = cfg.correct_enable ? corr_x : sat16_of32(x_sel);
	assign new_y    = cfg.correct_enable ? corr_y : sat16_of32(y_sel);

	always_comb begin
		res.contact_state = frame_state_q;
		res.coord_x       = frame_up ? last_x_q : new_x;
		res.coord_y       = frame_up ? last_y_q : new_y;
		res.pressure      = held_pressure_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_state_q   <= ST_NONE;
			frame_x_q       <= '0;
			frame_y_q       <= '0;
			held_pressure_q <= '0;
			last_x_q        <= '0;
			last_y_q        <= '0;
		end else if (evt_en) begin
			if (is_key) begin
				if (evt.event_code == KEY_CONTACT) begin
					frame_state_q <= (evt.event_value != '0) ? ST_DOWN : ST_UP;
				end
			end else if (is_abs) begin
				if (evt.event_code == ABS_X) begin
					frame_x_q <= mirror_sat;
				end else if (evt.event_code == ABS_Y) begin
					frame_y_q <= evt.event_value;
				end else if (evt.event_code == ABS_PRESS) begin
					held_pressure_q <= evt.event_value;
				end
			end else if (is_syn) begin
				if (!frame_up) begin
					last_x_q <= new_x;
					last_y_q <= new_y;
				end
				frame_state_q <= ST_NONE;
				frame_x_q     <= '0;
				frame_y_q     <= '0;
			end
		end
	end
endmodule

>>> design/touch_event_assembler_affine_top.sv
// Channel   Dir  Handshake                        Payload
// s_axis    in   s_axis_tvalid / s_axis_tready    tuser: event_type; tdata: code, value
// m_axis    out  m_axis_tvalid / m_axis_tready    tuser: contact_state; tdata: x, y, pressure
// cfg       in   cfg_valid / cfg_ready            cfg_index, cfg_data
// One event per cycle while no sync event is held back: an input register, then the frame
// update and four 32x32 multipliers feeding the result register.
// Reset clears frame state, last coordinates and configuration to their defaults.
// A sync event stalls in the input register only while a result waits unclaimed.
// Depends on tea_pkg, tea_cfg_regs, tea_frame and the defines header.
`include "touch_event_assembler_affine_top_defines.svh"
module touch_event_assembler_affine_top
	import tea_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [47:0]          s_axis_tdata,  // [15:0] event_code, [47:16] event_value
	input  logic [15:0]          s_axis_tuser,  // [15:0] event_type
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [63:0]          m_axis_tdata,  // [15:0] coord_x, [31:16] coord_y, [63:32] pressure
	output logic [1:0]           m_axis_tuser,  // [1:0] contact_state
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);
	cfg_t    cfg;
	event_t  evt_s1;
	logic    valid_s1;
	logic    sync_s1;
	logic    advance;
	logic    out_load;
	logic    in_fire;
	result_t res;
	result_t res_q;
	logic    out_valid_q;

	assign cfg_ready = 1'b1;

	tea_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign sync_s1       = (evt_s1.event_type == EV_SYN);
	assign advance       = valid_s1 && (!sync_s1 || !out_valid_q || m_axis_tready);
	assign out_load      = advance && sync_s1;
	assign s_axis_tready = !valid_s1 || advance;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			evt_s1.event_type  <= s_axis_tuser;
			evt_s1.event_code  <= s_axis_tdata[15:0];
			evt_s1.event_value <= s_axis_tdata[47:16];
		end
	end

	tea_frame u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.evt_en (advance),
		.evt    (evt_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = res_q.contact_state;
	assign m_axis_tdata  = {res_q.pressure, res_q.coord_y, res_q.coord_x};

	`TEA_ASSERT_NEXT(a_load_shows, clk, arst_n, out_load, out_valid_q)
	`TEA_ASSERT_SAME(a_no_overwrite, clk, arst_n, out_valid_q && !m_axis_tready, !out_load)
	`TEA_ASSERT_SAME(a_load_needs_item, clk, arst_n, out_load, valid_s1 && sync_s1)
	`TEA_ASSERT_SAME(a_state_code, clk, arst_n, out_valid_q, m_axis_tuser != 2'd3)
endmodule

>>> tb/touch_event_assembler_affine_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for touch_event_assembler_affine_top: directed, correction,
// backpressure and random event streams checked against an in-bench frame predictor.
// Depends on tea_pkg and the touch_event_assembler_affine_top RTL.
module touch_event_assembler_affine_top_tb;
	import tea_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [47:0]          s_axis_tdata;  // [15:0] event_code, [47:16] event_value
	logic [15:0]          s_axis_tuser;  // [15:0] event_type
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [63:0]          m_axis_tdata;  // [15:0] coord_x, [31:16] coord_y, [63:32] pressure
	logic [1:0]           m_axis_tuser;  // [1:0] contact_state
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	touch_event_assembler_affine_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Predictor state
	cfg_t               model_cfg;
	contact_state_t     pend_state;
	logic signed [31:0] pend_x;
	logic signed [31:0] pend_y;
	logic signed [31:0] held_press;
	logic signed [15:0] rep_x;
	logic signed [15:0] rep_y;
	result_t            expected_reports[$];

	int fail_count = 0;
	int cycle_count = 0;
	int burst_left = 0;
	bit idle_enable = 1'b1;
	bit stall_enable = 1'b1;
	int hold_request = 0;
	int hold_left = 0;
	int stall_left = 0;

	function automatic logic signed [15:0] clip16(input logic signed [71:0] v);
		logic signed [15:0] r;
		if (v > 72'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -72'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	function automatic logic signed [15:0] corrected_coord(input logic signed [31:0] cx,
			input logic signed [31:0] cy, input logic signed [31:0] off,
			input logic signed [31:0] px, input logic signed [31:0] py);
		logic signed [71:0] a;
		logic signed [71:0] b;
		logic signed [71:0] c;
		logic signed [71:0] d;
		logic signed [71:0] e;
		logic signed [71:0] acc;
		a = cx;
		b = px;
		c = cy;
		d = py;
		e = off;
		acc = a * b + c * d + e;
		return clip16(acc / 72'sd65536);
	endfunction

	task automatic predict_touch_report(input logic [15:0] ev_type, input logic [15:0] ev_code,
			input logic signed [31:0] ev_value);
		logic signed [33:0] mirrored;
		logic signed [31:0] raw_x;
		logic signed [31:0] raw_y;
		result_t rep;
		case (ev_type)
			EV_KEY: begin
				if (ev_code == KEY_CONTACT) pend_state = (ev_value != 0) ? ST_DOWN : ST_UP;
			end
			EV_ABS: begin
				if (ev_code == ABS_X) begin
					mirrored = PANEL_SIZE - ev_value;
					if (mirrored > 34'sd2147483647) begin
						pend_x = 32'sh7fffffff;
					end else if (mirrored < -34'sd2147483648) begin
						pend_x = 32'sh80000000;
					end else begin
						pend_x = mirrored[31:0];
					end
				end else if (ev_code == ABS_Y) begin
					pend_y = ev_value;
				end else if (ev_code == ABS_PRESS) begin
					held_press = ev_value;
				end
			end
			EV_SYN: begin
				if (pend_state != ST_UP) begin
					raw_x = (pend_x != 0) ? pend_x : rep_x;
					raw_y = (pend_y != 0) ? pend_y : rep_y;
					if (model_cfg.correct_enable) begin
						rep_x = corrected_coord(model_cfg.x_from_x, model_cfg.x_from_y,
							model_cfg.x_offset, raw_x, raw_y);
						rep_y = corrected_coord(model_cfg.y_from_x, model_cfg.y_from_y,
							model_cfg.y_offset, raw_x, raw_y);
					end else begin
						rep_x = clip16(raw_x);
						rep_y = clip16(raw_y);
					end
				end
				rep.contact_state = pend_state;
				rep.coord_x = rep_x;
				rep.coord_y = rep_y;
				rep.pressure = held_press;
				expected_reports.push_back(rep);
				pend_state = ST_NONE;
				pend_x = '0;
				pend_y = '0;
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_event(input logic [15:0] ev_type, input logic [15:0] ev_code,
			input logic signed [31:0] ev_value);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = idle_enable ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= ev_type;
		s_axis_tdata <= {ev_value, ev_code};
		do @(posedge clk); while (!s_axis_tready);
		predict_touch_report(ev_type, ev_code, ev_value);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_CORRECT_ENABLE: model_cfg.correct_enable = data[0];
			CFG_X_FROM_X:       model_cfg.x_from_x = data;
			CFG_X_FROM_Y:       model_cfg.x_from_y = data;
			CFG_X_OFFSET:       model_cfg.x_offset = data;
			CFG_Y_FROM_X:       model_cfg.y_from_x = data;
			CFG_Y_FROM_Y:       model_cfg.y_from_y = data;
			CFG_Y_OFFSET:       model_cfg.y_offset = data;
			default: begin
			end
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Drop valid, hold until every report is in, then let the pipeline drain.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [31:0] random_axis_value();
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0: v = 32'd0;
			1: v = PANEL_SIZE;
			2: v = $urandom;
			3: v = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: v = $urandom_range(0, 40000);
		endcase
		return v;
	endfunction

	function automatic logic [31:0] random_key_value();
		logic [31:0] v;
		case ($urandom_range(0, 4))
			0, 1: v = 32'd1;
			2, 3: v = 32'd0;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] pick_coeff(input int phase, input logic [31:0] nominal);
		logic [31:0] v;
		case (phase)
			1: v = nominal + $urandom_range(0, 16384) - 32'd8192;
			3: begin
				case ($urandom_range(0, 3))
					0: v = 32'h80000000;
					1: v = 32'h7fffffff;
					2: v = 32'd0;
					default: v = nominal;
				endcase
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic send_random_frame(output int sent);
		int rot;
		int k;
		int slot;
		logic [15:0] code;
		bit key_last;
		sent = 0;
		rot = $urandom_range(0, 2);
		key_last = $urandom_range(0, 1);
		if (!key_last && $urandom_range(0, 9) < 7) begin
			code = ($urandom_range(0, 9) == 0) ? 16'($urandom) : KEY_CONTACT;
			send_event(EV_KEY, code, random_key_value());
			sent++;
		end
		for (k = 0; k < 3; k++) begin
			slot = (k + rot) % 3;
			if ($urandom_range(0, 9) < 8) begin
				code = (slot == 0) ? ABS_X : ((slot == 1) ? ABS_Y : ABS_PRESS);
				if ($urandom_range(0, 19) == 0) code = 16'($urandom);
				send_event(EV_ABS, code, random_axis_value());
				sent++;
			end
		end
		if (key_last && $urandom_range(0, 9) < 7) begin
			send_event(EV_KEY, KEY_CONTACT, random_key_value());
			sent++;
		end
		if ($urandom_range(0, 6) == 0) send_event(16'($urandom), 16'($urandom), $urandom);
		if ($urandom_range(0, 9) != 0) begin
			send_event(EV_SYN, 16'($urandom), $urandom);
			sent++;
		end
	endtask

	task automatic test_directed();
		send_event(EV_SYN, 16'h0000, 32'd0);
		send_event(EV_KEY, KEY_CONTACT, 32'd1);
		send_event(EV_ABS, ABS_X, 32'd100);
		send_event(EV_ABS, ABS_Y, 32'd200);
		send_event(EV_ABS, ABS_PRESS, 32'd50);
		send_event(EV_SYN, 16'hffff, 32'hffffffff);
		send_event(EV_KEY, KEY_CONTACT, 32'd0);
		send_event(EV_ABS, ABS_X, 32'd5);
		send_event(EV_SYN, 16'h0000, 32'd0);
		send_event(EV_ABS, ABS_X, PANEL_SIZE);
		send_event(EV_ABS, ABS_Y, 32'd0);
		send_event(EV_SYN, 16'h0000, 32'd0);
		send_event(EV_ABS, ABS_X, 32'h80000000);
		send_event(EV_ABS, ABS_Y, 32'h7fffffff);
		send_event(EV_SYN, 16'h0000, 32'd0);
		send_event(EV_ABS, ABS_X, 32'h7fffffff);
		send_event(EV_ABS, ABS_Y, 32'h80000000);
		send_event(EV_KEY, KEY_CONTACT, 32'h80000000);
		send_event(EV_SYN, 16'h0000, 32'd0);
		send_event(16'h0002, ABS_X, 32'd7);
		send_event(16'hffff, 16'hffff, 32'hffffffff);
		send_event(EV_KEY, 16'h0100, 32'd1);
		send_event(EV_ABS, 16'hffff, 32'd9);
		send_event(EV_SYN, 16'h0000, 32'd0);
		wait_idle();
	endtask

	task automatic test_correction();
		write_reg(CFG_CORRECT_ENABLE, 32'd1);
		write_reg(CFG_X_FROM_X, 32'hffffffff);
		write_reg(CFG_X_FROM_Y, 32'd0);
		write_reg(CFG_X_OFFSET, 32'd0);
		write_reg(CFG_Y_FROM_X, 32'd0);
		write_reg(CFG_Y_FROM_Y, 32'd65536);
		write_reg(CFG_Y_OFFSET, 32'hffff0000);
		send_event(EV_ABS, ABS_X, PANEL_SIZE - 100);
		send_event(EV_ABS, ABS_Y, 32'd50);
		send_event(EV_SYN, 16'h0000, 32'd0);
		wait_idle();
		write_reg(CFG_X_FROM_X, 32'h7fffffff);
		write_reg(CFG_X_FROM_Y, 32'h7fffffff);
		write_reg(CFG_X_OFFSET, 32'h7fffffff);
		write_reg(CFG_Y_FROM_X, 32'h80000000);
		write_reg(CFG_Y_FROM_Y, 32'h80000000);
		write_reg(CFG_Y_OFFSET, 32'h80000000);
		send_event(EV_ABS, ABS_X, 32'h80000000);
		send_event(EV_ABS, ABS_Y, 32'h7fffffff);
		send_event(EV_SYN, 16'h0000, 32'd0);
		send_event(EV_ABS, ABS_X, 32'h7fffffff);
		send_event(EV_ABS, ABS_Y, 32'h80000000);
		send_event(EV_SYN, 16'h0000, 32'd0);
		wait_idle();
		write_reg(CFG_UNUSED_INDEX, 32'hffffffff);
		write_reg(CFG_CORRECT_ENABLE, 32'hfffffffe);
		send_event(EV_ABS, ABS_X, 32'd1000);
		send_event(EV_ABS, ABS_Y, 32'd40000);
		send_event(EV_SYN, 16'h0000, 32'd0);
		wait_idle();
	endtask

	task automatic test_backpressure();
		int k;
		idle_enable = 1'b0;
		stall_enable = 1'b0;
		hold_request = 300;
		for (k = 0; k < 30; k++) begin
			send_event(EV_ABS, ABS_X, $urandom_range(0, 5000));
			send_event(EV_ABS, ABS_Y, $urandom_range(0, 5000));
			send_event(EV_SYN, 16'h0000, 32'd0);
		end
		wait_idle();
		idle_enable = 1'b1;
		stall_enable = 1'b1;
	endtask

	task automatic test_random();
		int phase;
		int sent;
		int total;
		logic [31:0] enable_word;
		for (phase = 0; phase < 4; phase++) begin
			wait_idle();
			enable_word = $urandom;
			enable_word[0] = (phase != 0);
			write_reg(CFG_CORRECT_ENABLE, enable_word);
			write_reg(CFG_X_FROM_X, pick_coeff(phase, 32'd65536));
			write_reg(CFG_X_FROM_Y, pick_coeff(phase, 32'd0));
			write_reg(CFG_X_OFFSET, pick_coeff(phase, 32'd0));
			write_reg(CFG_Y_FROM_X, pick_coeff(phase, 32'd0));
			write_reg(CFG_Y_FROM_Y, pick_coeff(phase, 32'd65536));
			write_reg(CFG_Y_OFFSET, pick_coeff(phase, 32'd0));
			idle_enable = (phase != 3);
			stall_enable = (phase != 3);
			total = 0;
			while (total < 165) begin
				send_random_frame(sent);
				total += sent;
			end
		end
		wait_idle();
	endtask

	// Report checker and receiver stall pattern
	always @(posedge clk) begin : report_sink
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_reports.size() == 0) begin
				$error("unexpected report transaction: state %0d x %0d y %0d",
					m_axis_tuser, $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]));
				fail_count++;
			end else begin
				want = expected_reports.pop_front();
				if (m_axis_tuser !== want.contact_state) begin
					$error("contact_state: expected %0d, actual %0d", want.contact_state,
						m_axis_tuser);
					fail_count++;
				end
				if (m_axis_tdata[15:0] !== want.coord_x) begin
					$error("coord_x: expected %0d, actual %0d", want.coord_x,
						$signed(m_axis_tdata[15:0]));
					fail_count++;
				end
				if (m_axis_tdata[31:16] !== want.coord_y) begin
					$error("coord_y: expected %0d, actual %0d", want.coord_y,
						$signed(m_axis_tdata[31:16]));
					fail_count++;
				end
				if (m_axis_tdata[63:32] !== want.pressure) begin
					$error("pressure: expected %0d, actual %0d", want.pressure,
						$signed(m_axis_tdata[63:32]));
					fail_count++;
				end
			end
		end
		if (arst_n) begin
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (!stall_enable) begin
				m_axis_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				stall_left = $urandom_range(0, 7);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		model_cfg.correct_enable = 1'b0;
		model_cfg.x_from_x = 32'sd65536;
		model_cfg.x_from_y = '0;
		model_cfg.x_offset = '0;
		model_cfg.y_from_x = '0;
		model_cfg.y_from_y = 32'sd65536;
		model_cfg.y_offset = '0;
		pend_state = ST_NONE;
		pend_x = '0;
		pend_y = '0;
		held_press = '0;
		rep_x = '0;
		rep_y = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_correction();
		test_backpressure();
		test_random();
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
